### rtl/core/encoder_actuator_positioner_defines.svh
// ----------------------------------------------------------------------------
// Encoder actuator positioner assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ENCODER_ACTUATOR_POSITIONER_DEFINES_SVH
`define ENCODER_ACTUATOR_POSITIONER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define EAP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define EAP_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define EAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/eap_pkg.sv
// ----------------------------------------------------------------------------
// Encoder actuator positioner package
// Shared widths, types and codes for the positioner.
// ----------------------------------------------------------------------------
`default_nettype none

package eap_pkg;

   // Width of the tracked position and target, two's complement, wrapping.
   localparam int POS_WIDTH = 24;

   localparam int DIST_WIDTH = 16;
   localparam int DUTY_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic [POS_WIDTH-1:0]  pos_type;
   typedef logic signed [POS_WIDTH:0] wide_type;
   typedef logic [DIST_WIDTH-1:0] dist_type;
   typedef logic [DUTY_WIDTH-1:0] duty_type;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_MOVE   = 2'd1,
      CMD_HOME   = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_STEP_SIZE    = 2'd0,
      CSR_DECEL_OFFSET = 2'd1,
      CSR_HOME_OFFSET  = 2'd2,
      CSR_DRIVE_POWER  = 2'd3
   } csr_index_type;

   localparam dist_type STEP_SIZE_RESET    = 16'd26;
   localparam dist_type DECEL_OFFSET_RESET = 16'd172;
   localparam dist_type HOME_OFFSET_RESET  = 16'd256;
   localparam duty_type DRIVE_POWER_RESET  = 8'd255;
   localparam pos_type  LAST_SEEN_RESET    = pos_type'(256);

endpackage

`default_nettype wire

### rtl/core/encoder_actuator_positioner.sv
// ----------------------------------------------------------------------------
// Encoder actuator positioner
// Quadrature-counted linear actuator position control with homing.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle on the req_ channel unless the rsp_
// side stalls, and returns exactly one result word per request in the cycle
// after acceptance. All work for a request (encoder count, move or homing start,
// stop check) is done between the request edge and the result register in a
// single pass, so a new request is accepted every cycle while the result
// register is empty or being drained; the cycle time is set by the position
// add followed by the signed target compare. Registers are written through the
// csr_ port, one per cycle, and should only be changed while the block is idle.
`default_nettype none

`include "encoder_actuator_positioner_defines.svh"

module encoder_actuator_positioner
   import eap_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [DIST_WIDTH-1:0]       csr_data,

   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [1:0]                  req_command,
   input  wire logic                        req_enc_a,
   input  wire logic                        req_enc_b,
   input  wire logic [DIST_WIDTH-1:0]       req_move_distance,
   input  wire logic                        req_move_extend,

   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [DUTY_WIDTH-1:0]       rsp_drive_duty,
   output      logic                        rsp_drive_extend,
   output      logic                        rsp_drive_retract,
   output      logic signed [POS_WIDTH-1:0] rsp_position_now,
   output      logic                        rsp_busy_res,
   output      logic                        rsp_move_done,
   output      logic                        rsp_rejected
);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_MOVE = 2'd1,
      MODE_HRET = 2'd2,
      MODE_HEXT = 2'd3
   } mode_type;

   // Configuration registers
   dist_type step_size_ff, decel_offset_ff, home_offset_ff;
   duty_type drive_power_ff;

   // Control state
   mode_type mode_ff, mode_in;
   pos_type  position_ff, position_in;
   pos_type  target_ff, target_in;
   pos_type  last_seen_ff, last_seen_in;
   logic     prev_a_ff, prev_a_in;
   logic     prev_b_ff, prev_b_in;
   logic     moving_out_ff, moving_out_in;
   logic     drive_out_ff, drive_out_in;

   // Result register
   logic     rsp_valid_ff, rsp_valid_in;
   duty_type rsp_drive_duty_ff, rsp_drive_duty_in;
   logic     rsp_drive_extend_ff, rsp_drive_extend_in;
   logic     rsp_drive_retract_ff, rsp_drive_retract_in;
   pos_type  rsp_position_ff, rsp_position_in;
   logic     rsp_busy_ff, rsp_busy_in;
   logic     rsp_done_ff, rsp_done_in;
   logic     rsp_rejected_ff, rsp_rejected_in;

   logic     req_accept;
   logic     csr_accept;
   cmd_type  cmd;

   // Intermediate values after the command, before the stop check.
   mode_type mode_mid;
   pos_type  position_mid;
   pos_type  target_mid;
   logic     moving_out_mid;
   logic     rejected;
   logic     reached;
   logic     done;
   logic     run;
   logic     below_dist;
   pos_type  move_target;
   pos_type  home_target;

   assign cmd        = cmd_type'(req_command);
   assign req_ready  = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = !reset;
   assign csr_accept = csr_valid && csr_ready;

   assign below_dist = $signed(wide_type'($signed(position_ff)))
                       < $signed(wide_type'(req_move_distance));

   assign move_target = req_move_extend
      ? pos_type'(position_ff + pos_type'(req_move_distance) - pos_type'(decel_offset_ff))
      : pos_type'(position_ff - pos_type'(req_move_distance) + pos_type'(decel_offset_ff));

   assign home_target =
      pos_type'(position_ff + pos_type'(home_offset_ff) - pos_type'(decel_offset_ff));

   always_comb begin
      mode_mid       = mode_ff;
      position_mid   = position_ff;
      target_mid     = target_ff;
      moving_out_mid = moving_out_ff;
      drive_out_in   = drive_out_ff;
      last_seen_in   = last_seen_ff;
      prev_a_in      = prev_a_ff;
      prev_b_in      = prev_b_ff;
      rejected       = 1'b0;

      case (cmd)
         CMD_SAMPLE: begin
            // A falling with B held high counts outward, B falling with A high inward.
            if (prev_a_ff && !req_enc_a && prev_b_ff && req_enc_b) begin
               moving_out_mid = 1'b1;
               position_mid   = pos_type'(position_ff + pos_type'(step_size_ff));
            end else if (prev_a_ff && req_enc_a && prev_b_ff && !req_enc_b) begin
               moving_out_mid = 1'b0;
               position_mid   = pos_type'(position_ff - pos_type'(step_size_ff));
            end
            prev_a_in = req_enc_a;
            prev_b_in = req_enc_b;
         end
         CMD_MOVE: begin
            if (mode_ff == MODE_IDLE) begin
               if (!req_move_extend && below_dist) begin
                  rejected = 1'b1;
               end else begin
                  moving_out_mid = req_move_extend;
                  drive_out_in   = req_move_extend;
                  target_mid     = move_target;
                  mode_mid       = MODE_MOVE;
               end
            end
         end
         CMD_HOME: begin
            if (mode_ff == MODE_IDLE) begin
               moving_out_mid = 1'b0;
               drive_out_in   = 1'b0;
               mode_mid       = MODE_HRET;
            end
         end
         CMD_TICK: begin
            // The end stop is found when a tick sees the position unchanged.
            if (mode_ff == MODE_HRET) begin
               if (position_ff != last_seen_ff) begin
                  last_seen_in = position_ff;
               end else begin
                  moving_out_mid = 1'b1;
                  drive_out_in   = 1'b1;
                  target_mid     = home_target;
                  mode_mid       = MODE_HEXT;
               end
            end
         end
         default: begin
         end
      endcase

      reached = moving_out_mid ? ($signed(position_mid) >= $signed(target_mid))
                               : ($signed(position_mid) <= $signed(target_mid));

      mode_in        = mode_mid;
      position_in    = position_mid;
      target_in      = target_mid;
      moving_out_in  = moving_out_mid;
      done           = 1'b0;
      if ((mode_mid == MODE_MOVE || mode_mid == MODE_HEXT) && reached) begin
         if (mode_mid == MODE_HEXT) begin
            position_in = '0;
         end
         mode_in = MODE_IDLE;
         done    = 1'b1;
      end

      run                  = (mode_in != MODE_IDLE);
      rsp_drive_duty_in    = run ? drive_power_ff : '0;
      rsp_drive_extend_in  = run && drive_out_in;
      rsp_drive_retract_in = run && !drive_out_in;
      rsp_position_in      = position_in;
      rsp_busy_in          = run;
      rsp_done_in          = done;
      rsp_rejected_in      = rejected;

      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff    <= STEP_SIZE_RESET;
         decel_offset_ff <= DECEL_OFFSET_RESET;
         home_offset_ff  <= HOME_OFFSET_RESET;
         drive_power_ff  <= DRIVE_POWER_RESET;
      end else if (csr_accept) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_SIZE:    step_size_ff    <= csr_data;
            CSR_DECEL_OFFSET: decel_offset_ff <= csr_data;
            CSR_HOME_OFFSET:  home_offset_ff  <= csr_data;
            CSR_DRIVE_POWER:  drive_power_ff  <= csr_data[DUTY_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         position_ff   <= '0;
         target_ff     <= '0;
         last_seen_ff  <= LAST_SEEN_RESET;
         prev_a_ff     <= 1'b0;
         prev_b_ff     <= 1'b0;
         moving_out_ff <= 1'b0;
         drive_out_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            mode_ff       <= mode_in;
            position_ff   <= position_in;
            target_ff     <= target_in;
            last_seen_ff  <= last_seen_in;
            prev_a_ff     <= prev_a_in;
            prev_b_ff     <= prev_b_in;
            moving_out_ff <= moving_out_in;
            drive_out_ff  <= drive_out_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_drive_duty_ff    <= rsp_drive_duty_in;
         rsp_drive_extend_ff  <= rsp_drive_extend_in;
         rsp_drive_retract_ff <= rsp_drive_retract_in;
         rsp_position_ff      <= rsp_position_in;
         rsp_busy_ff          <= rsp_busy_in;
         rsp_done_ff          <= rsp_done_in;
         rsp_rejected_ff      <= rsp_rejected_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_duty    = rsp_drive_duty_ff;
   assign rsp_drive_extend  = rsp_drive_extend_ff;
   assign rsp_drive_retract = rsp_drive_retract_ff;
   assign rsp_position_now  = $signed(rsp_position_ff);
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_move_done     = rsp_done_ff;
   assign rsp_rejected      = rsp_rejected_ff;

   `EAP_ASSERT_NEXT(a_accept_gives_word, clock, reset, req_accept, rsp_valid_ff, "accepted request produced no result word")
   `EAP_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_done_ff, !rsp_busy_ff, "finished move still reported busy")
   `EAP_ASSERT_SAME(a_reject_idle, clock, reset, rsp_valid_ff && rsp_rejected_ff, !rsp_busy_ff && !rsp_done_ff, "rejected move changed the motion state")
   `EAP_ASSERT_SAME(a_idle_drive_off, clock, reset, rsp_valid_ff && !rsp_busy_ff, rsp_drive_duty_ff == '0 && !rsp_drive_extend_ff && !rsp_drive_retract_ff, "bridge driven while idle")
   `EAP_ASSERT_SAME(a_busy_one_dir, clock, reset, rsp_valid_ff && rsp_busy_ff, rsp_drive_extend_ff != rsp_drive_retract_ff, "bridge direction not exclusive while busy")

endmodule

`default_nettype wire

### sim/encoder_actuator_positioner_tb.sv
// ----------------------------------------------------------------------------
// Encoder actuator positioner testbench
// Drives encoder samples, moves and homing through the request channel with
// random idle bursts on both sides, predicts every result word with an
// independent model of the positioner and compares each field on the fly.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_actuator_positioner_tb;
   import eap_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;

   typedef enum logic [1:0] {
      MODE_IDLE         = 2'd0,
      MODE_MOVE         = 2'd1,
      MODE_HOME_RETRACT = 2'd2,
      MODE_HOME_EXTEND  = 2'd3
   } run_mode_type;

   typedef struct packed {
      duty_type duty;
      logic     extend;
      logic     retract;
      pos_type  position;
      logic     busy;
      logic     done;
      logic     rejected;
   } drive_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [DIST_WIDTH-1:0]      csr_data = '0;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_command = '0;
   logic                       req_enc_a = 1'b0;
   logic                       req_enc_b = 1'b0;
   logic [DIST_WIDTH-1:0]      req_move_distance = '0;
   logic                       req_move_extend = 1'b0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [DUTY_WIDTH-1:0]      rsp_drive_duty;
   logic                       rsp_drive_extend;
   logic                       rsp_drive_retract;
   logic signed [POS_WIDTH-1:0] rsp_position_now;
   logic                       rsp_busy_res;
   logic                       rsp_move_done;
   logic                       rsp_rejected;

   encoder_actuator_positioner dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_enc_a         (req_enc_a),
      .req_enc_b         (req_enc_b),
      .req_move_distance (req_move_distance),
      .req_move_extend   (req_move_extend),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive_duty    (rsp_drive_duty),
      .rsp_drive_extend  (rsp_drive_extend),
      .rsp_drive_retract (rsp_drive_retract),
      .rsp_position_now  (rsp_position_now),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_move_done     (rsp_move_done),
      .rsp_rejected      (rsp_rejected)
   );

   // Predicted configuration and controller state.
   dist_type     cfg_step;
   dist_type     cfg_decel;
   dist_type     cfg_home;
   duty_type     cfg_power;
   pos_type      est_position;
   logic         est_prev_a;
   logic         est_prev_b;
   logic         est_moving_out;
   pos_type      est_target;
   run_mode_type est_mode;
   pos_type      est_last_seen;
   logic         est_drive_out;

   drive_result_type expected_drive_q[$];
   int               fail_count = 0;
   int               items_sent = 0;
   bit               sender_gaps = 1'b1;
   bit               sink_stalls = 1'b1;
   int               stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** encoder_actuator_positioner: FAILED **");
      $finish;
   end

   function automatic void predict_reset();
      cfg_step       = STEP_SIZE_RESET;
      cfg_decel      = DECEL_OFFSET_RESET;
      cfg_home       = HOME_OFFSET_RESET;
      cfg_power      = DRIVE_POWER_RESET;
      est_position   = '0;
      est_prev_a     = 1'b0;
      est_prev_b     = 1'b0;
      est_moving_out = 1'b0;
      est_target     = '0;
      est_mode       = MODE_IDLE;
      est_last_seen  = LAST_SEEN_RESET;
      est_drive_out  = 1'b0;
   endfunction

   function automatic pos_type move_target(dist_type distance, logic extend);
      if (extend)
         return est_position + pos_type'(distance) - pos_type'(cfg_decel);
      return est_position - pos_type'(distance) + pos_type'(cfg_decel);
   endfunction

   function automatic drive_result_type predict_drive_state(cmd_type cmd, logic a, logic b,
                                                            dist_type distance, logic ext);
      drive_result_type r;
      logic             done;
      logic             rej;
      logic             reached;
      logic             run;
      done = 1'b0;
      rej  = 1'b0;
      case (cmd)
         CMD_SAMPLE: begin
            if (est_prev_a && !a && est_prev_b && b) begin
               est_moving_out = 1'b1;
               est_position   = est_position + pos_type'(cfg_step);
            end else if (est_prev_a && a && est_prev_b && !b) begin
               est_moving_out = 1'b0;
               est_position   = est_position - pos_type'(cfg_step);
            end
            est_prev_a = a;
            est_prev_b = b;
         end
         CMD_MOVE: begin
            if (est_mode == MODE_IDLE) begin
               // A retract that would pass zero is refused and leaves all state alone.
               if (!ext && (int'($signed(est_position)) < int'(distance))) begin
                  rej = 1'b1;
               end else begin
                  est_moving_out = ext;
                  est_drive_out  = ext;
                  est_target     = move_target(distance, ext);
                  est_mode       = MODE_MOVE;
               end
            end
         end
         CMD_HOME: begin
            if (est_mode == MODE_IDLE) begin
               est_moving_out = 1'b0;
               est_drive_out  = 1'b0;
               est_mode       = MODE_HOME_RETRACT;
            end
         end
         CMD_TICK: begin
            if (est_mode == MODE_HOME_RETRACT) begin
               if (est_position != est_last_seen) begin
                  est_last_seen = est_position;
               end else begin
                  est_moving_out = 1'b1;
                  est_drive_out  = 1'b1;
                  est_target     = move_target(cfg_home, 1'b1);
                  est_mode       = MODE_HOME_EXTEND;
               end
            end
         end
         default: begin
         end
      endcase
      if (est_mode == MODE_MOVE || est_mode == MODE_HOME_EXTEND) begin
         reached = est_moving_out ? ($signed(est_position) >= $signed(est_target))
                                  : ($signed(est_position) <= $signed(est_target));
         if (reached) begin
            if (est_mode == MODE_HOME_EXTEND)
               est_position = '0;
            est_mode = MODE_IDLE;
            done     = 1'b1;
         end
      end
      run        = (est_mode != MODE_IDLE);
      r.duty     = run ? cfg_power : '0;
      r.extend   = run && est_drive_out;
      r.retract  = run && !est_drive_out;
      r.position = est_position;
      r.busy     = run;
      r.done     = done;
      r.rejected = rej;
      return r;
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Result sink with random stall bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drive_q.size() == 0) begin
            $error("result word arrived with no prediction pending");
            fail_count++;
         end else begin
            want = expected_drive_q.pop_front();
            check_field("drive_duty", want.duty, rsp_drive_duty);
            check_field("drive_extend", want.extend, rsp_drive_extend);
            check_field("drive_retract", want.retract, rsp_drive_retract);
            check_field("position_now", $signed(want.position), rsp_position_now);
            check_field("busy_res", want.busy, rsp_busy_res);
            check_field("move_done", want.done, rsp_move_done);
            check_field("rejected", want.rejected, rsp_rejected);
         end
      end
   end

   task automatic send_word(cmd_type cmd, logic a, logic b, dist_type distance, logic ext);
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_enc_a         <= a;
      req_enc_b         <= b;
      req_move_distance <= distance;
      req_move_extend   <= ext;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_drive_q.push_back(predict_drive_state(cmd, a, b, distance, ext));
      items_sent++;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic sample(logic a, logic b);
      send_word(CMD_SAMPLE, a, b, dist_type'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
   endtask

   // One counted transition: both channels high, then the matching channel falls.
   task automatic count_step(logic extend);
      sample(1'b1, 1'b1);
      sample(!extend, extend);
   endtask

   task automatic start_move(dist_type distance, logic ext);
      send_word(CMD_MOVE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), distance, ext);
   endtask

   task automatic start_homing();
      send_word(CMD_HOME, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                dist_type'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endtask

   task automatic homing_tick();
      send_word(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                dist_type'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endtask

   task automatic random_word();
      send_word(cmd_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), dist_type'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, dist_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_STEP_SIZE:    cfg_step  = data;
         CSR_DECEL_OFFSET: cfg_decel = data;
         CSR_HOME_OFFSET:  cfg_home  = data;
         CSR_DRIVE_POWER:  cfg_power = data[DUTY_WIDTH-1:0];
         default: begin
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_registers(dist_type step, dist_type decel, dist_type home,
                                  dist_type power);
      drain_pipeline();
      write_csr(CSR_STEP_SIZE, step);
      write_csr(CSR_DECEL_OFFSET, decel);
      write_csr(CSR_HOME_OFFSET, home);
      write_csr(CSR_DRIVE_POWER, power);
   endtask

   // Ends a move or homing with an opposite count, or with ticks while homing
   // retracts, so the block is idle before its registers change.
   task automatic settle_idle();
      int tries;
      for (tries = 0; tries < 8 && est_mode != MODE_IDLE; tries++) begin
         if (est_mode == MODE_HOME_RETRACT)
            homing_tick();
         else
            count_step(!est_moving_out);
      end
   endtask

   task automatic random_traffic(int n_items);
      int   start;
      int   dist_i;
      int   pos_i;
      int   n;
      logic ext;
      start = items_sent;
      while (items_sent - start < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               dist_i = int'(cfg_step) * $urandom_range(0, 16) + $urandom_range(0, cfg_step);
               if (dist_i > 65535)
                  dist_i = 65535;
               ext   = 1'($urandom_range(0, 1));
               pos_i = $signed(est_position);
               // Most retracts are kept short enough to be accepted.
               if (!ext && pos_i < dist_i && $urandom_range(0, 3) != 0) begin
                  if (pos_i >= 0)
                     dist_i = $urandom_range(0, (pos_i > 65535) ? 65535 : pos_i);
                  else
                     ext = 1'b1;
               end
               start_move(dist_type'(dist_i), ext);
               for (n = 0; n < 40 && est_mode == MODE_MOVE; n++) begin
                  if ($urandom_range(0, 9) == 0)
                     random_word();
                  else
                     count_step(ext);
               end
            end
            5, 6: begin
               start_homing();
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(0, 1) != 0)
                     count_step(1'b0);
                  else
                     homing_tick();
               end
               homing_tick();
               homing_tick();
               for (n = 0; n < 40 && est_mode == MODE_HOME_EXTEND; n++) begin
                  if ($urandom_range(0, 9) == 0)
                     random_word();
                  else
                     count_step(1'b1);
               end
            end
            default: begin
               repeat ($urandom_range(1, 8)) random_word();
            end
         endcase
         settle_idle();
         if ($urandom_range(0, 29) == 0)
            drain_pipeline();
      end
   endtask

   task automatic test_reset_state();
      sample(1'b0, 1'b0);
   endtask

   task automatic test_encoder_counts();
      count_step(1'b1);
      count_step(1'b0);
      // Both channels falling together is not a counted transition.
      sample(1'b1, 1'b1);
      sample(1'b0, 1'b0);
   endtask

   task automatic test_move_commands();
      start_move(16'd1, 1'b0);
      start_move(16'd0, 1'b0);
      start_move(16'd200, 1'b1);
      // Start commands and ticks are ignored while a move runs.
      start_homing();
      homing_tick();
      start_move(16'hFFFF, 1'b0);
      count_step(1'b1);
      count_step(1'b1);
   endtask

   task automatic test_homing();
      int n;
      start_homing();
      homing_tick();
      homing_tick();
      for (n = 0; n < 8 && est_mode == MODE_HOME_EXTEND; n++)
         count_step(1'b1);
   endtask

   task automatic test_random_traffic();
      int step;
      write_registers(16'hFFFF, 16'd0, 16'hFFFF, 16'h0000);
      random_traffic(150);
      write_registers(16'd1, 16'hFFFF, 16'd0, 16'hFFFF);
      random_traffic(100);
      repeat (4) begin
         step = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
         write_registers(dist_type'(step),
                         dist_type'($urandom_range(0, (3 * step > 65535) ? 65535 : 3 * step)),
                         dist_type'($urandom_range(0, (10 * step > 65535) ? 65535 : 10 * step)),
                         dist_type'($urandom_range(0, 65535)));
         random_traffic(170);
      end
   endtask

   task automatic test_steady_stream();
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      random_traffic(100);
   endtask

   initial begin
      predict_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_encoder_counts();
      test_move_commands();
      test_homing();
      test_random_traffic();
      test_steady_stream();
      drain_pipeline();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** encoder_actuator_positioner: PASSED **");
      else
         $display("** encoder_actuator_positioner: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
